/* sv/fme_pkg.sv */
// ----------------------------------------------------------------------------
// fme_pkg
// shared types and constants of the fuzzy membership evaluator
// ----------------------------------------------------------------------------
package fme_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_KIND  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_POINT  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PEAK_POINT  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_POINT = CFG_INDEX_W'(3);

  localparam logic [1:0] SHAPE_TRIANGLE       = 2'd0;
  localparam logic [1:0] SHAPE_LEFT_SHOULDER  = 2'd1;
  localparam logic [1:0] SHAPE_RIGHT_SHOULDER = 2'd2;

  // how the final membership is formed from the quotient
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ONE  = 2'd1,
    RES_RISE = 2'd2,
    RES_FALL = 2'd3
  } res_kind_t;

endpackage

/* sv/fuzzy_membership_eval.sv */
// ----------------------------------------------------------------------------
// fuzzy_membership_eval
// degree of membership of a position in a triangle or shoulder fuzzy set
// ----------------------------------------------------------------------------
// Usage: write shape_kind, left_point, peak_point and right_point through the
// cfg channel (cfg_index selects the register) while the block is idle. Then
// stream positions in on s_tvalid/s_tready/s_tdata; each item yields one result
// item on m_tvalid/m_tready/m_tdata with the membership (unsigned, ONE means
// 1.0) and the set's representative point.
// Throughput: one item per cycle while the output is not stalled. The slope
// divider is a restoring divider with one quotient bit per pipeline stage
// (FRAC_BITS+1 stages), behind one range-test stage and followed by one output
// register.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. Items in flight keep moving as
// long as the output register is empty or being drained.
// Reset: all pipeline valid bits clear, the config registers return to 0
// (triangle with all points at 0). cfg_ready is always high.
// ----------------------------------------------------------------------------
module fuzzy_membership_eval #(
  parameter int POS_WIDTH = 16,
  parameter int FRAC_BITS = 15
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // cfg channel
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [fme_pkg::CFG_INDEX_W-1:0]             cfg_index,
  input  logic [POS_WIDTH-1:0]                        cfg_data,
  // input items
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // position
  input  logic [((POS_WIDTH+7)/8)*8-1:0]              s_tdata,
  // result items
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // membership, representative_point
  output logic [((FRAC_BITS+1+POS_WIDTH+7)/8)*8-1:0]  m_tdata
);

  localparam int W      = POS_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int NS     = FRAC_BITS + 1;
  localparam int DATA_W = ((FRAC_BITS + 1 + POS_WIDTH + 7) / 8) * 8;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  // config registers
  logic [1:0]   shape_kind;
  logic [W-1:0] left_point;
  logic [W-1:0] peak_point;
  logic [W-1:0] right_point;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind  <= '0;
      left_point  <= '0;
      peak_point  <= '0;
      right_point <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fme_pkg::REG_SHAPE_KIND:  shape_kind  <= cfg_data[1:0];
        fme_pkg::REG_LEFT_POINT:  left_point  <= cfg_data;
        fme_pkg::REG_PEAK_POINT:  peak_point  <= cfg_data;
        fme_pkg::REG_RIGHT_POINT: right_point <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // range tests
  logic signed [W:0] pos_x, lft_x, pk_x, rgt_x;
  logic signed [W:0] sum_lp, sum_rp, d_pos_pk, d_rgt_pk, d_pos_lft, d_pk_lft;
  fme_pkg::res_kind_t kind_next;
  logic [W-1:0]      num_next, den_next, rep_next;

  assign pos_x = {s_tdata[W-1], s_tdata[W-1:0]};
  assign lft_x = {left_point[W-1], left_point};
  assign pk_x  = {peak_point[W-1], peak_point};
  assign rgt_x = {right_point[W-1], right_point};

  assign sum_lp    = lft_x + pk_x;
  assign sum_rp    = rgt_x + pk_x;
  assign d_pos_pk  = pos_x - pk_x;
  assign d_rgt_pk  = rgt_x - pk_x;
  assign d_pos_lft = pos_x - lft_x;
  assign d_pk_lft  = pk_x - lft_x;

  always_comb begin
    kind_next = fme_pkg::RES_ZERO;
    num_next  = '0;
    den_next  = '0;
    rep_next  = '0;
    unique case (shape_kind)
      fme_pkg::SHAPE_TRIANGLE: begin
        rep_next = peak_point;
        priority if (pos_x <= rgt_x && pos_x > pk_x) begin
          kind_next = fme_pkg::RES_FALL;
          num_next  = d_pos_pk[W-1:0];
          den_next  = d_rgt_pk[W-1:0];
        end else if (pos_x >= lft_x && pos_x < pk_x) begin
          kind_next = fme_pkg::RES_RISE;
          num_next  = d_pos_lft[W-1:0];
          den_next  = d_pk_lft[W-1:0];
        end else if (pos_x == pk_x) begin
          kind_next = fme_pkg::RES_ONE;
        end else begin
          kind_next = fme_pkg::RES_ZERO;
        end
      end
      fme_pkg::SHAPE_LEFT_SHOULDER: begin
        rep_next = sum_lp[W:1];
        priority if (pos_x >= lft_x && pos_x <= pk_x) begin
          kind_next = fme_pkg::RES_ONE;
        end else if (pos_x > pk_x && pos_x <= rgt_x) begin
          kind_next = fme_pkg::RES_FALL;
          num_next  = d_pos_pk[W-1:0];
          den_next  = d_rgt_pk[W-1:0];
        end else begin
          kind_next = fme_pkg::RES_ZERO;
        end
      end
      fme_pkg::SHAPE_RIGHT_SHOULDER: begin
        rep_next = sum_rp[W:1];
        priority if (pos_x <= rgt_x && pos_x >= pk_x) begin
          kind_next = fme_pkg::RES_ONE;
        end else if (pos_x < pk_x && pos_x >= lft_x) begin
          kind_next = fme_pkg::RES_RISE;
          num_next  = d_pos_lft[W-1:0];
          den_next  = d_pk_lft[W-1:0];
        end else begin
          kind_next = fme_pkg::RES_ZERO;
        end
      end
      default: begin
        kind_next = fme_pkg::RES_ZERO;
        rep_next  = '0;
      end
    endcase
  end

  // divider pipeline, stage k holds k quotient bits
  logic               st_valid [0:NS];
  logic [W:0]         st_rem   [0:NS];
  logic [W-1:0]       st_den   [0:NS];
  logic [F:0]         st_quo   [0:NS];
  fme_pkg::res_kind_t st_kind  [0:NS];
  logic [W-1:0]       st_rep   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (advance) begin
      st_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st_rem[0]  <= {1'b0, num_next};
      st_den[0]  <= den_next;
      st_quo[0]  <= '0;
      st_kind[0] <= kind_next;
      st_rep[0]  <= rep_next;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [W:0] r_in;
    logic [W:0] r_sub;
    logic       q_bit;

    if (k == 0) begin : g_first
      assign r_in = st_rem[k];
    end else begin : g_shift
      assign r_in = {st_rem[k][W-1:0], 1'b0};
    end

    assign r_sub = r_in - {1'b0, st_den[k]};
    assign q_bit = r_in >= {1'b0, st_den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (advance) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st_rem[k+1]  <= q_bit ? r_sub : r_in;
        st_den[k+1]  <= st_den[k];
        st_quo[k+1]  <= {st_quo[k][F-1:0], q_bit};
        st_kind[k+1] <= st_kind[k];
        st_rep[k+1]  <= st_rep[k];
      end
    end
  end

  // output register
  logic [F:0]   membership;
  logic [W-1:0] representative_point;
  logic [F:0]   membership_next;

  always_comb begin
    unique case (st_kind[NS])
      fme_pkg::RES_ZERO: membership_next = '0;
      fme_pkg::RES_ONE:  membership_next = ONE;
      fme_pkg::RES_RISE: membership_next = st_quo[NS];
      fme_pkg::RES_FALL: membership_next = ONE - st_quo[NS];
      default:           membership_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= st_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      membership           <= membership_next;
      representative_point <= st_rep[NS];
    end
  end

  assign m_tdata = DATA_W'({representative_point, membership});

  // checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    st_valid[0] && (st_kind[0] == fme_pkg::RES_RISE || st_kind[0] == fme_pkg::RES_FALL)
    |-> st_den[0] != '0 && st_rem[0] <= {1'b0, st_den[0]})
    else $error("slope operands out of range");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    st_valid[NS] && (st_kind[NS] == fme_pkg::RES_RISE || st_kind[NS] == fme_pkg::RES_FALL)
    |-> st_quo[NS] <= ONE && st_rem[NS] < {1'b0, st_den[NS]})
    else $error("slope quotient exceeds one");

  a_mem_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> membership <= ONE)
    else $error("membership above one");

endmodule
